FILE: rtl/core/dnshc_pkg.sv
package dnshc_pkg;

    // Name and label limits of the host name rules.
    localparam int unsigned MaxNameLen     = 253;
    localparam int unsigned MaxLabelLen    = 63;
    localparam int unsigned LocalhostLen   = 9;
    localparam int unsigned Ipv4Dots       = 3;
    localparam int unsigned MinWildcardLen = 5;

    // Counter widths.
    localparam int unsigned NameLenW  = 9;
    localparam int unsigned LabelLenW = 7;
    localparam int unsigned DotCntW   = 3;

    // Character codes that the checker looks for.
    localparam logic [7:0] ChDot    = 8'h2E;
    localparam logic [7:0] ChStar   = 8'h2A;
    localparam logic [7:0] ChHyphen = 8'h2D;

    // Classification of one character of the name.
    typedef struct packed {
        logic [7:0] lower;
        logic       is_digit;
        logic       is_alpha;
        logic       is_hyphen;
        logic       is_dot;
        logic       is_star;
    } char_class_t;

    // Characters of the word "localhost", by position.
    function automatic logic [7:0] localhost_char(input logic [3:0] pos);
        logic [7:0] c;
        begin
            case (pos)
                4'd0:    c = 8'h6C; // l
                4'd1:    c = 8'h6F; // o
                4'd2:    c = 8'h63; // c
                4'd3:    c = 8'h61; // a
                4'd4:    c = 8'h6C; // l
                4'd5:    c = 8'h68; // h
                4'd6:    c = 8'h6F; // o
                4'd7:    c = 8'h73; // s
                4'd8:    c = 8'h74; // t
                default: c = 8'h00;
            endcase
            return c;
        end
    endfunction

endpackage

FILE: rtl/core/dnshc_char_class.sv
module dnshc_char_class
    import dnshc_pkg::*;
(
    input  logic [7:0]  char_code,
    output char_class_t char_class
);

    logic [7:0] lower;

    // Fold upper-case letters to lower case.
    always_comb
    begin
        if (char_code >= 8'h41 && char_code <= 8'h5A)
        begin
            lower = char_code | 8'h20;
        end
        else
        begin
            lower = char_code;
        end
    end

    // Character classes used by the label rules.
    always_comb
    begin
        char_class.lower     = lower;
        char_class.is_digit  = (lower >= 8'h30) && (lower <= 8'h39);
        char_class.is_alpha  = (lower >= 8'h61) && (lower <= 8'h7A);
        char_class.is_hyphen = (lower == ChHyphen);
        char_class.is_dot    = (char_code == ChDot);
        char_class.is_star   = (char_code == ChStar);
    end

endmodule

FILE: rtl/core/dnshc_tracker.sv
module dnshc_tracker
    import dnshc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  logic        is_last,
    input  char_class_t char_class,
    output logic        verdict
);

    logic [NameLenW-1:0]  name_length_reg, name_length_next;
    logic [LabelLenW-1:0] label_length_reg, label_length_next;
    logic [DotCntW-1:0]   dot_count_reg, dot_count_next;
    logic prev_hyphen_reg, prev_hyphen_next;
    logic all_digits_reg, all_digits_next;
    logic wildcard_seen_reg, wildcard_seen_next;
    logic star_pending_reg, star_pending_next;
    logic localhost_match_reg, localhost_match_next;
    logic failed_reg, failed_next;

    // State after this character, before the end-of-name clear.
    logic [NameLenW-1:0]  upd_name_length;
    logic [LabelLenW-1:0] upd_label_length;
    logic [DotCntW-1:0]   upd_dot_count;
    logic upd_prev_hyphen;
    logic upd_all_digits;
    logic upd_wildcard_seen;
    logic upd_star_pending;
    logic upd_localhost_match;
    logic upd_failed;

    logic [NameLenW-1:0] pos;
    logic [NameLenW-1:0] stripped_len;
    logic [DotCntW-1:0]  label_dots;
    logic                trail_dot;
    logic                ok;

    assign pos = name_length_reg;

    // Per-character update of counters and flags.
    always_comb
    begin
        upd_name_length     = name_length_reg;
        upd_label_length    = label_length_reg;
        upd_dot_count       = dot_count_reg;
        upd_prev_hyphen     = prev_hyphen_reg;
        upd_all_digits      = all_digits_reg;
        upd_wildcard_seen   = wildcard_seen_reg;
        upd_star_pending    = star_pending_reg;
        upd_localhost_match = localhost_match_reg;
        upd_failed          = failed_reg;

        if (name_length_reg != {NameLenW{1'b1}})
        begin
            upd_name_length = name_length_reg + 1'b1;
        end

        if (pos < NameLenW'(LocalhostLen) &&
            char_class.lower != localhost_char(pos[3:0]))
        begin
            upd_localhost_match = 1'b0;
        end

        if (pos == '0 && char_class.is_star)
        begin
            upd_star_pending = 1'b1;
        end
        else if (pos == NameLenW'(1) && star_pending_reg)
        begin
            // A leading star must be followed by a dot.
            upd_star_pending = 1'b0;
            if (char_class.is_dot)
            begin
                upd_wildcard_seen = 1'b1;
            end
            else
            begin
                upd_failed = 1'b1;
            end
        end
        else if (char_class.is_dot)
        begin
            // A dot closes a label, which must be non-empty and not end in a hyphen.
            if (label_length_reg == '0 || prev_hyphen_reg)
            begin
                upd_failed = 1'b1;
            end
            if (dot_count_reg != {DotCntW{1'b1}})
            begin
                upd_dot_count = dot_count_reg + 1'b1;
            end
            upd_label_length = '0;
            upd_prev_hyphen  = 1'b0;
        end
        else
        begin
            if (!(char_class.is_digit || char_class.is_alpha || char_class.is_hyphen))
            begin
                upd_failed = 1'b1;
            end
            if (char_class.is_hyphen && label_length_reg == '0)
            begin
                upd_failed = 1'b1;
            end
            upd_prev_hyphen = char_class.is_hyphen;
            if (!char_class.is_digit)
            begin
                upd_all_digits = 1'b0;
            end
            if (label_length_reg != {LabelLenW{1'b1}})
            begin
                upd_label_length = label_length_reg + 1'b1;
            end
            if (upd_label_length > LabelLenW'(MaxLabelLen))
            begin
                upd_failed = 1'b1;
            end
        end
    end

    // Verdict for a name that ends with this character.
    always_comb
    begin
        trail_dot    = char_class.is_dot;
        stripped_len = upd_name_length - {{(NameLenW-1){1'b0}}, trail_dot};
        if (trail_dot && upd_dot_count != '0)
        begin
            label_dots = upd_dot_count - 1'b1;
        end
        else
        begin
            label_dots = upd_dot_count;
        end

        ok = !upd_failed && !upd_star_pending && stripped_len != '0 &&
             stripped_len <= NameLenW'(MaxNameLen);
        if (upd_wildcard_seen && stripped_len < NameLenW'(MinWildcardLen))
        begin
            ok = 1'b0;
        end
        if (!trail_dot && (upd_label_length == '0 || upd_prev_hyphen))
        begin
            ok = 1'b0;
        end
        if (ok)
        begin
            if (label_dots == '0)
            begin
                // A single-label name passes only as localhost.
                ok = !upd_wildcard_seen && stripped_len == NameLenW'(LocalhostLen) &&
                     upd_localhost_match;
            end
            else if (!upd_wildcard_seen && upd_all_digits &&
                     label_dots == DotCntW'(Ipv4Dots))
            begin
                // Four numeric labels form an address literal.
                ok = 1'b0;
            end
        end
        verdict = ok;
    end

    // Next state: the update, or a fresh start after the final character.
    always_comb
    begin
        name_length_next     = name_length_reg;
        label_length_next    = label_length_reg;
        dot_count_next       = dot_count_reg;
        prev_hyphen_next     = prev_hyphen_reg;
        all_digits_next      = all_digits_reg;
        wildcard_seen_next   = wildcard_seen_reg;
        star_pending_next    = star_pending_reg;
        localhost_match_next = localhost_match_reg;
        failed_next          = failed_reg;
        if (step)
        begin
            if (is_last)
            begin
                name_length_next     = '0;
                label_length_next    = '0;
                dot_count_next       = '0;
                prev_hyphen_next     = 1'b0;
                all_digits_next      = 1'b1;
                wildcard_seen_next   = 1'b0;
                star_pending_next    = 1'b0;
                localhost_match_next = 1'b1;
                failed_next          = 1'b0;
            end
            else
            begin
                name_length_next     = upd_name_length;
                label_length_next    = upd_label_length;
                dot_count_next       = upd_dot_count;
                prev_hyphen_next     = upd_prev_hyphen;
                all_digits_next      = upd_all_digits;
                wildcard_seen_next   = upd_wildcard_seen;
                star_pending_next    = upd_star_pending;
                localhost_match_next = upd_localhost_match;
                failed_next          = upd_failed;
            end
        end
    end

    // Name state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            name_length_reg     <= '0;
            label_length_reg    <= '0;
            dot_count_reg       <= '0;
            prev_hyphen_reg     <= 1'b0;
            all_digits_reg      <= 1'b1;
            wildcard_seen_reg   <= 1'b0;
            star_pending_reg    <= 1'b0;
            localhost_match_reg <= 1'b1;
            failed_reg          <= 1'b0;
        end
        else
        begin
            name_length_reg     <= name_length_next;
            label_length_reg    <= label_length_next;
            dot_count_reg       <= dot_count_next;
            prev_hyphen_reg     <= prev_hyphen_next;
            all_digits_reg      <= all_digits_next;
            wildcard_seen_reg   <= wildcard_seen_next;
            star_pending_reg    <= star_pending_next;
            localhost_match_reg <= localhost_match_next;
            failed_reg          <= failed_next;
        end
    end

endmodule

FILE: rtl/core/dns_hostname_syntax_check.sv
// DNS host name syntax checker, one verdict per name.
// The verdict is registered: the final character goes from the input register
// to the verdict register, which holds it while the verdict side stalls.
// It takes one character item per cycle unless char_stall is high.
// Reset (rst_n, asynchronous, active low) empties both registers and starts a new name.
module dns_hostname_syntax_check
    import dnshc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       char_valid,
    output logic       char_stall,
    input  logic [7:0] char_code,
    input  logic       is_last,
    output logic       verdict_valid,
    input  logic       verdict_stall,
    output logic       looks_like_dns
);

    logic       in_valid_reg, in_valid_next;
    logic [7:0] char_reg;
    logic       last_reg;
    logic       out_valid_reg, out_valid_next;
    logic       verdict_reg;

    logic        out_free;
    logic        step;
    logic        take;
    logic        verdict;
    char_class_t char_class;

    // A character is processed unless it ends a name and the verdict slot is full.
    assign out_free   = !out_valid_reg || !verdict_stall;
    assign step       = in_valid_reg && (!last_reg || out_free);
    assign char_stall = in_valid_reg && !step;
    assign take       = char_valid && !char_stall;

    dnshc_char_class u_class (
        .char_code  (char_reg),
        .char_class (char_class)
    );

    dnshc_tracker u_tracker (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .is_last    (last_reg),
        .char_class (char_class),
        .verdict    (verdict)
    );

    // Valid flags of the input and result registers.
    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (take)
        begin
            in_valid_next = 1'b1;
        end
        else if (step)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (step && last_reg)
        begin
            out_valid_next = 1'b1;
        end
        else if (!verdict_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            char_reg <= char_code;
            last_reg <= is_last;
        end
        if (step && last_reg)
        begin
            verdict_reg <= verdict;
        end
    end

    assign verdict_valid  = out_valid_reg;
    assign looks_like_dns = verdict_reg;

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import dnshc_pkg::*;

    typedef logic [7:0] name_t[$];

    // Character codes used by the local host name model.
    localparam logic [7:0] ChUpperA = 8'h41;
    localparam logic [7:0] ChUpperZ = 8'h5A;
    localparam logic [7:0] ChLowerA = 8'h61;
    localparam logic [7:0] ChLowerZ = 8'h7A;
    localparam logic [7:0] ChZero   = 8'h30;
    localparam logic [7:0] ChNine   = 8'h39;
    localparam logic [8*LocalhostLen-1:0] LocalhostWord = "localhost";

    localparam int unsigned CycleLimit  = 500000;
    localparam int          RandomChars = 100;
    localparam int          QuietChars  = 70;
    localparam int          ErrorPrints = 100;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       char_valid;
    logic       char_stall;
    logic [7:0] char_code;
    logic       is_last;
    logic       verdict_valid;
    logic       verdict_stall;
    logic       looks_like_dns;

    // Local copy of the per-name checker state.
    logic [NameLenW-1:0]  nm_length;
    logic [LabelLenW-1:0] nm_label_len;
    logic [DotCntW-1:0]   nm_dots;
    bit                   nm_prev_hyphen;
    bit                   nm_all_digits;
    bit                   nm_wildcard;
    bit                   nm_star_pending;
    bit                   nm_localhost;
    bit                   nm_broken;

    bit          expected_verdicts[$];
    int          errors = 0;
    int          verdicts_checked = 0;
    int          chars_sent = 0;
    int          names_sent = 0;
    int          names_accepted = 0;
    int unsigned cycle_count = 0;
    bit          idle_on = 1'b1;
    int          hold_request = 0;

    dns_hostname_syntax_check DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .char_valid     (char_valid),
        .char_stall     (char_stall),
        .char_code      (char_code),
        .is_last        (is_last),
        .verdict_valid  (verdict_valid),
        .verdict_stall  (verdict_stall),
        .looks_like_dns (looks_like_dns)
    );

    // The clock runs with a 10 ns period.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // The run is cut off if it takes far longer than any correct run could.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CycleLimit)
        begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("dns_hostname_syntax_check verification failed");
            $finish;
        end
    end

    // Start a new name in the local model.
    function automatic void clear_name_state();
        nm_length       = '0;
        nm_label_len    = '0;
        nm_dots         = '0;
        nm_prev_hyphen  = 1'b0;
        nm_all_digits   = 1'b1;
        nm_wildcard     = 1'b0;
        nm_star_pending = 1'b0;
        nm_localhost    = 1'b1;
        nm_broken       = 1'b0;
    endfunction

    // Advance the host name rules by one character; returns 1 when a verdict is due.
    function automatic bit hostname_step(input logic [7:0] code, input bit last,
                                         output bit verdict);
        int         pos;
        int         len;
        int         seps;
        logic [7:0] lc;
        bit         is_dig;
        bit         is_alpha;
        bit         is_hyph;
        bit         trail;
        verdict = 1'b0;
        pos = int'(nm_length);
        lc = (code >= ChUpperA && code <= ChUpperZ) ? (code | 8'h20) : code;

        if (nm_length != '1)
            nm_length = nm_length + 1'b1;
        if (pos < LocalhostLen && lc != LocalhostWord[8*(LocalhostLen-1-pos) +: 8])
            nm_localhost = 1'b0;

        // A leading star must be followed by a dot; otherwise classify the character.
        if (pos == 0 && code == ChStar)
        begin
            nm_star_pending = 1'b1;
        end
        else if (pos == 1 && nm_star_pending)
        begin
            nm_star_pending = 1'b0;
            if (code == ChDot)
                nm_wildcard = 1'b1;
            else
                nm_broken = 1'b1;
        end
        else if (code == ChDot)
        begin
            if (nm_label_len == 0 || nm_prev_hyphen)
                nm_broken = 1'b1;
            if (nm_dots != '1)
                nm_dots = nm_dots + 1'b1;
            nm_label_len   = '0;
            nm_prev_hyphen = 1'b0;
        end
        else
        begin
            is_dig   = lc >= ChZero && lc <= ChNine;
            is_alpha = lc >= ChLowerA && lc <= ChLowerZ;
            is_hyph  = lc == ChHyphen;
            if (!(is_dig || is_alpha || is_hyph))
                nm_broken = 1'b1;
            if (is_hyph && nm_label_len == 0)
                nm_broken = 1'b1;
            nm_prev_hyphen = is_hyph;
            if (!is_dig)
                nm_all_digits = 1'b0;
            if (nm_label_len != '1)
                nm_label_len = nm_label_len + 1'b1;
            if (nm_label_len > MaxLabelLen)
                nm_broken = 1'b1;
        end

        if (!last)
            return 1'b0;

        // Final character: strip one trailing dot and apply the whole-name rules.
        trail = code == ChDot;
        len   = int'(nm_length) - (trail ? 1 : 0);
        seps  = int'(nm_dots);
        if (trail && seps > 0)
            seps = seps - 1;
        verdict = !nm_broken && !nm_star_pending && len >= 1 && len <= int'(MaxNameLen);
        if (nm_wildcard && len < int'(MinWildcardLen))
            verdict = 1'b0;
        if (!trail && (nm_label_len == 0 || nm_prev_hyphen))
            verdict = 1'b0;
        if (verdict)
        begin
            if (seps == 0)
                verdict = !nm_wildcard && len == int'(LocalhostLen) && nm_localhost;
            else if (!nm_wildcard && nm_all_digits && seps == int'(Ipv4Dots))
                verdict = 1'b0;
        end
        clear_name_state();
        return 1'b1;
    endfunction

    function automatic name_t text_name(input string s);
        name_t n;
        for (int i = 0; i < s.len(); i++)
            n.push_back(s[i]);
        return n;
    endfunction

    // Labels of repeated 'a' each ending in a dot, then a tail of repeated 'b'.
    function automatic name_t long_name(input int seg_len, input int labels, input int tail);
        name_t n;
        for (int l = 0; l < labels; l++)
        begin
            for (int k = 0; k < seg_len; k++)
                n.push_back(ChLowerA);
            n.push_back(ChDot);
        end
        for (int k = 0; k < tail; k++)
            n.push_back(8'h62);
        return n;
    endfunction

    // One legal label character; a hyphen is never picked at a label end.
    function automatic logic [7:0] label_char(input bit at_end);
        int r;
        r = $urandom_range(0, at_end ? 61 : 62);
        if (r < 26)
            return 8'(ChLowerA + r);
        if (r < 52)
            return 8'(ChUpperA + r - 26);
        if (r < 62)
            return 8'(ChZero + r - 52);
        return ChHyphen;
    endfunction

    // Random names: mostly well formed, some digit-only, localhost-like, corrupted or noise.
    function automatic name_t random_name();
        name_t      n;
        int         kind;
        int         labels;
        int         width;
        int         idx;
        logic [7:0] ch;
        kind = $urandom_range(0, 99);
        if (kind < 60 || (kind >= 75 && kind < 90))
        begin
            if ($urandom_range(0, 5) == 0)
            begin
                n.push_back(ChStar);
                n.push_back(ChDot);
            end
            labels = $urandom_range(1, 5);
            for (int l = 0; l < labels; l++)
            begin
                width = ($urandom_range(0, 19) == 0) ? $urandom_range(55, 66)
                                                     : $urandom_range(1, 10);
                for (int k = 0; k < width; k++)
                    n.push_back(label_char(k == 0 || k == width - 1));
                if (l != labels - 1)
                    n.push_back(ChDot);
            end
            if ($urandom_range(0, 3) == 0)
                n.push_back(ChDot);
            // Corrupt one character of the name.
            if (kind >= 75)
            begin
                idx = $urandom_range(0, n.size() - 1);
                case ($urandom_range(0, 3))
                    0:       n[idx] = 8'($urandom_range(0, 255));
                    1:       n[idx] = ChHyphen;
                    2:       n[idx] = ChDot;
                    default: n[idx] = ChStar;
                endcase
            end
        end
        else if (kind < 70)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                n.push_back(ChStar);
                n.push_back(ChDot);
            end
            labels = $urandom_range(3, 5);
            for (int l = 0; l < labels; l++)
            begin
                width = $urandom_range(1, 3);
                for (int k = 0; k < width; k++)
                    n.push_back(8'(ChZero + $urandom_range(0, 9)));
                if (l != labels - 1)
                    n.push_back(ChDot);
            end
            if ($urandom_range(0, 3) == 0)
                n.push_back(ChDot);
        end
        else if (kind < 75)
        begin
            for (int k = 0; k < LocalhostLen; k++)
            begin
                ch = LocalhostWord[8*(LocalhostLen-1-k) +: 8];
                n.push_back($urandom_range(0, 1) ? (ch & 8'hDF) : ch);
            end
            case ($urandom_range(0, 3))
                0: n.push_back(ChDot);
                1: n.push_back(8'h78);
                2: void'(n.pop_back());
                default: ;
            endcase
        end
        else
        begin
            width = $urandom_range(1, 12);
            for (int k = 0; k < width; k++)
                n.push_back(8'($urandom_range(0, 255)));
        end
        return n;
    endfunction

    // Offer one character item, after an optional gap, and predict once it is taken.
    task automatic send_char(input logic [7:0] code, input bit last);
        int gap;
        bit verdict;
        if (idle_on && $urandom_range(0, 9) == 0)
        begin
            gap = $urandom_range(1, 17);
            @(negedge clk);
            char_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        char_valid <= 1'b1;
        char_code  <= code;
        is_last    <= last;
        @(posedge clk);
        while (char_stall)
            @(posedge clk);
        chars_sent++;
        if (hostname_step(code, last, verdict))
        begin
            expected_verdicts.push_back(verdict);
            if (verdict)
                names_accepted++;
        end
    endtask

    task automatic send_name(input name_t n);
        for (int i = 0; i < n.size(); i++)
            send_char(n[i], i == n.size() - 1);
        names_sent++;
    endtask

    task automatic send_text(input string s);
        send_name(text_name(s));
    endtask

    // Stop offering items until every predicted verdict has come back.
    task automatic wait_for_verdicts();
        @(negedge clk);
        char_valid <= 1'b0;
        while (expected_verdicts.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_localhost();
        send_text("localhost");
        send_text("LOCALHOST");
        send_text("LocalHost");
        send_text("localhost.");
        send_text("localhos");
        send_text("localhostt");
        send_text("localhosx");
        send_text("host");
        send_text("l");
    endtask

    task automatic test_labels();
        send_text("a.b");
        send_text("example.com");
        send_text("EXAMPLE.COM.");
        send_text("a-b.c");
        send_text("-a.b");
        send_text("a-.b");
        send_text("a..b");
        send_text(".a");
        send_text(".");
        send_text("..");
        send_text("a.b..");
        send_text("a.b-");
        send_text("a.-b");
        send_text("a-");
    endtask

    // Bytes on both sides of the digit and letter ranges, including byte zero.
    task automatic test_characters();
        logic [7:0] probes [16] = '{8'h00, 8'h2F, 8'h30, 8'h39, 8'h3A, 8'h40, 8'h41, 8'h5A,
                                    8'h5B, 8'h5F, 8'h60, 8'h61, 8'h7A, 8'h7B, 8'h80, 8'hFF};
        name_t      n;
        foreach (probes[i])
        begin
            n = text_name("ab.com");
            n[1] = probes[i];
            send_name(n);
        end
    endtask

    task automatic test_wildcard();
        send_text("*.ab");
        send_text("*.a.b");
        send_text("*.a.b.");
        send_text("*.a");
        send_text("*x.com");
        send_text("*");
        send_text("*.");
        send_text("**.com");
        send_text("a*.b");
        send_text("*.*.com");
        send_text("*.localhost");
    endtask

    task automatic test_ipv4();
        send_text("1.2.3.4");
        send_text("1.2.3.4.");
        send_text("10.20.30.40");
        send_text("0.0.0.0");
        send_text("1.2.3.4.5");
        send_text("1.2.3");
        send_text("1.2.3.a");
        send_text("*.1.2.3.4");
    endtask

    // Label and name length limits on both sides, and enough dots to saturate their count.
    task automatic test_lengths();
        send_name(long_name(64, 1, 1));
        send_name(long_name(63, 3, 61));
        send_name(long_name(63, 3, 62));
        send_name(long_name(1, 9, 1));
    endtask

    // Hold the verdict side for a long stretch while items keep coming.
    task automatic test_backpressure();
        idle_on = 1'b0;
        hold_request = 150;
        for (int i = 0; i < 12; i++)
        begin
            if (i % 3 == 0)
                send_text("a.io");
            else
                send_text("x");
        end
        wait (hold_request == 0);
        wait_for_verdicts();
        idle_on = 1'b1;
    endtask

    task automatic test_random();
        name_t n;
        int    start;
        start = chars_sent;
        while (chars_sent - start < RandomChars)
        begin
            if (chars_sent - start >= QuietChars)
                idle_on = 1'b0;
            n = random_name();
            send_name(n);
            if ($urandom_range(0, 29) == 0)
                wait_for_verdicts();
        end
    endtask

    // The verdict side stalls in random bursts, or for a requested long hold.
    initial
    begin : verdict_stall_gen
        int burst;
        verdict_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request != 0)
            begin
                verdict_stall <= 1'b1;
                repeat (hold_request) @(negedge clk);
                hold_request = 0;
                verdict_stall <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 11) == 0)
            begin
                burst = $urandom_range(1, 17);
                verdict_stall <= 1'b1;
                repeat (burst) @(negedge clk);
                verdict_stall <= 1'b0;
            end
            else
            begin
                verdict_stall <= 1'b0;
            end
        end
    end

    // Compare every verdict taken with the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && verdict_valid && !verdict_stall)
        begin
            verdicts_checked++;
            if (expected_verdicts.size() == 0)
            begin
                errors++;
                if (errors <= ErrorPrints)
                    $display("%0t: verdict with none pending: expected none, got %0b",
                             $time, looks_like_dns);
            end
            else if (expected_verdicts[0] != looks_like_dns)
            begin
                errors++;
                if (errors <= ErrorPrints)
                    $display("%0t: verdict mismatch: expected %0b, got %0b",
                             $time, expected_verdicts[0], looks_like_dns);
                void'(expected_verdicts.pop_front());
            end
            else
            begin
                void'(expected_verdicts.pop_front());
            end
        end
    end

    // Reset once, run the tests in turn, drain and report.
    initial
    begin
        rst_n      = 1'b0;
        char_valid = 1'b0;
        char_code  = '0;
        is_last    = 1'b0;
        clear_name_state();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_localhost();
        test_labels();
        test_characters();
        test_wildcard();
        test_ipv4();
        test_lengths();
        test_backpressure();
        test_random();

        wait_for_verdicts();
        repeat (4) @(posedge clk);
        errors = errors + expected_verdicts.size();

        $display("Run covered %0d names in %0d characters; %0d verdicts checked, %0d passing.",
                 names_sent, chars_sent, verdicts_checked, names_accepted);
        $display("Cases: localhost, wildcards, label and name limits, IPv4 forms, byte ranges.");
        if (errors == 0)
            $display("dns_hostname_syntax_check verification clean");
        else
            $display("dns_hostname_syntax_check verification failed");
        $finish;
    end

endmodule
